@@ rtl/pmpc_pkg.sv @@
package pmpc_pkg;

  // Field widths of the beats and the configuration registers.
  localparam int POS_W = 32;
  localparam int IDX_W = 31;
  localparam int POT_W = 56;
  localparam int BOX_W = 32;
  localparam int LIM_W = 8;
  localparam int CNT_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Default capacity and fixed-point format of the potentials.
  localparam int MAX_PARTICLES_DEF = 128;
  localparam int POT_FRAC_BITS = 24;

  // Squared distance, root and reciprocal widths.
  localparam int SQ_W = 2 * POS_W + 2;
  localparam int RAD_W = SQ_W + (SQ_W % 2);
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W = ROOT_W + 3;
  localparam int INV_W = 17 + POT_FRAC_BITS;
  localparam int NUM_W = 17 + POT_FRAC_BITS;
  localparam int STEP_W = $clog2((NUM_W > ROOT_W) ? NUM_W : ROOT_W);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT = 2'd1;

  localparam logic [BOX_W-1:0] BOX_RESET = 32'h0100_0000;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 8'd100;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } pos3_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [IDX_W-1:0] particle_index;
    logic             last_particle;
  } in_beat_t;

  typedef struct packed {
    logic                    center_found;
    logic [IDX_W-1:0]        center_index;
    logic signed [POT_W-1:0] min_potential;
  } out_beat_t;

endpackage

@@ rtl/pairwise_min_potential_center.sv @@
// Halo center finder. Particles of one halo stream in, one beat per cycle, the last
// beat marked; up to MAX_PARTICLES of them are stored. On the last beat the block
// stops taking beats and visits every pair once: minimum-image distance in the
// periodic box, square root and reciprocal, then subtracts 1/r from both potentials
// (saturating). It returns one beat: the index of the first particle with the least
// potential and that potential, or center_found 0 when the halo exceeds size_limit or
// MAX_PARTICLES. Most of the work per pair is spent in the shared root-and-divide
// unit, which resolves one result bit per cycle (33 root and 41 quotient bits). A
// zero-distance pair skips that unit. An oversized halo goes from its last beat
// straight to the result. A result waits while an earlier one is still held by
// out_stall.
module pairwise_min_potential_center #(
  parameter int MAX_PARTICLES = pmpc_pkg::MAX_PARTICLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pmpc_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pmpc_pkg::out_beat_t               out_data,
  input  logic                              cfg_we,
  input  logic [pmpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int POT_W = pmpc_pkg::POT_W;

  typedef struct packed {
    pmpc_pkg::pos3_t              pos;
    logic [pmpc_pkg::IDX_W-1:0]   idx;
  } entry_t;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_CLR  = 13'b0000000000010,
    S_LDI  = 13'b0000000000100,
    S_LDW  = 13'b0000000001000,
    S_RDJ  = 13'b0000000010000,
    S_CAPJ = 13'b0000000100000,
    S_SQ   = 13'b0000001000000,
    S_ROOT = 13'b0000010000000,
    S_UPD  = 13'b0000100000000,
    S_NEXT = 13'b0001000000000,
    S_MRD  = 13'b0010000000000,
    S_MCMP = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_t;

  // Configuration registers.
  logic [pmpc_pkg::BOX_W-1:0] box_r;
  logic [pmpc_pkg::LIM_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r   <= pmpc_pkg::BOX_RESET;
      limit_r <= pmpc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmpc_pkg::CFG_BOX_SIZE:   box_r   <= cfg_wdata[pmpc_pkg::BOX_W-1:0];
        pmpc_pkg::CFG_SIZE_LIMIT: limit_r <= cfg_wdata[pmpc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  state_t                       st_r, st_nxt;
  logic [pmpc_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [CW-1:0]                n_r, n_nxt;
  logic [CW-1:0]                i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic                         found_r, found_nxt;
  logic                         out_valid_r, out_valid_nxt;
  pmpc_pkg::out_beat_t          out_r, out_nxt;
  pmpc_pkg::pos3_t              posi_r, posi_nxt;
  logic signed [POT_W-1:0]      acc_r, acc_nxt;
  logic signed [POT_W-1:0]      potj_r, potj_nxt;
  logic signed [POT_W-1:0]      best_pot_r, best_pot_nxt;
  logic [pmpc_pkg::IDX_W-1:0]   best_idx_r, best_idx_nxt;

  // Particle store and potential accumulators.
  entry_t                       pos_mem [MAX_PARTICLES];
  entry_t                       pos_rd_r;
  logic signed [POT_W-1:0]      pot_mem [MAX_PARTICLES];
  logic signed [POT_W-1:0]      pot_rd_r;
  logic                         pos_we, pot_we;
  logic [AW-1:0]                pos_waddr, rd_addr, pot_waddr;
  entry_t                       pos_wdata;
  logic signed [POT_W-1:0]      pot_wdata;

  // Shared arithmetic units.
  logic                         sq_start, sq_done, sq_zero;
  logic [pmpc_pkg::SQ_W-1:0]    sq_sum;
  logic                         root_start, root_done;
  logic [pmpc_pkg::INV_W-1:0]   root_inv;

  logic                         in_acc;
  logic [pmpc_pkg::CNT_W-1:0]   cnt_new;

  pmpc_sq_sum u_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .pos_a (posi_r),
    .pos_b (pos_rd_r.pos),
    .box   (box_r),
    .done  (sq_done),
    .zero  (sq_zero),
    .sum   (sq_sum)
  );

  pmpc_root_div u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (sq_sum),
    .done     (root_done),
    .inv      (root_inv)
  );

  // Subtract 1/r from a potential, saturating at the most negative value.
  function automatic logic signed [POT_W-1:0] sub_sat(
    input logic signed [POT_W-1:0]        p,
    input logic [pmpc_pkg::INV_W-1:0]     v
  );
    logic signed [POT_W:0] t;
    t = {p[POT_W-1], p} - {(POT_W + 1 - pmpc_pkg::INV_W)'(0), v};
    if (t[POT_W] != t[POT_W-1]) begin
      sub_sat = {1'b1, (POT_W - 1)'(0)};
    end else begin
      sub_sat = t[POT_W-1:0];
    end
  endfunction

  assign in_stall  = (st_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cnt_new   = (count_r == '1) ? count_r : count_r + 1'b1;
  assign pos_we    = in_acc && (count_r < pmpc_pkg::CNT_W'(MAX_PARTICLES));
  assign pos_waddr = count_r[AW-1:0];
  assign pos_wdata = '{pos: '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z},
                       idx: in_data.particle_index};

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rd_r <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pot_we) begin
      pot_mem[pot_waddr] <= pot_wdata;
    end
    pot_rd_r <= pot_mem[rd_addr];
  end

  // Sequencer: intake, clear, pair sweep, minimum search, result.
  always_comb begin
    st_nxt        = st_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    posi_nxt      = posi_r;
    acc_nxt       = acc_r;
    potj_nxt      = potj_r;
    best_pot_nxt  = best_pot_r;
    best_idx_nxt  = best_idx_r;
    pot_we        = 1'b0;
    pot_waddr     = k_r[AW-1:0];
    pot_wdata     = '0;
    rd_addr       = k_r[AW-1:0];
    sq_start      = 1'b0;
    root_start    = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          count_nxt = cnt_new;
          if (in_data.last_particle) begin
            count_nxt = '0;
            k_nxt     = '0;
            if ((cnt_new > pmpc_pkg::CNT_W'(limit_r)) ||
                (cnt_new > pmpc_pkg::CNT_W'(MAX_PARTICLES))) begin
              found_nxt = 1'b0;
              st_nxt    = S_FIN;
            end else begin
              n_nxt  = cnt_new[CW-1:0];
              st_nxt = S_CLR;
            end
          end
        end
      end
      S_CLR: begin
        pot_we    = 1'b1;
        pot_waddr = k_r[AW-1:0];
        pot_wdata = '0;
        k_nxt     = k_r + 1'b1;
        if (k_r + 1'b1 == n_r) begin
          i_nxt = '0;
          k_nxt = '0;
          st_nxt = (n_r == CW'(1)) ? S_MRD : S_LDI;
        end
      end
      S_LDI: begin
        rd_addr = i_r[AW-1:0];
        st_nxt  = S_LDW;
      end
      S_LDW: begin
        posi_nxt = pos_rd_r.pos;
        acc_nxt  = pot_rd_r;
        j_nxt    = i_r + 1'b1;
        st_nxt   = S_RDJ;
      end
      S_RDJ: begin
        rd_addr = j_r[AW-1:0];
        st_nxt  = S_CAPJ;
      end
      S_CAPJ: begin
        potj_nxt = pot_rd_r;
        sq_start = 1'b1;
        st_nxt   = S_SQ;
      end
      S_SQ: begin
        if (sq_done) begin
          if (sq_zero) begin
            st_nxt = S_NEXT;
          end else begin
            root_start = 1'b1;
            st_nxt     = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        if (root_done) begin
          st_nxt = S_UPD;
        end
      end
      S_UPD: begin
        pot_we    = 1'b1;
        pot_waddr = j_r[AW-1:0];
        pot_wdata = sub_sat(potj_r, root_inv);
        acc_nxt   = sub_sat(acc_r, root_inv);
        st_nxt    = S_NEXT;
      end
      S_NEXT: begin
        if (j_r + 1'b1 == n_r) begin
          pot_we    = 1'b1;
          pot_waddr = i_r[AW-1:0];
          pot_wdata = acc_r;
          if (i_r + CW'(2) == n_r) begin
            k_nxt  = '0;
            st_nxt = S_MRD;
          end else begin
            i_nxt  = i_r + 1'b1;
            st_nxt = S_LDI;
          end
        end else begin
          j_nxt  = j_r + 1'b1;
          st_nxt = S_RDJ;
        end
      end
      S_MRD: begin
        rd_addr = k_r[AW-1:0];
        st_nxt  = S_MCMP;
      end
      S_MCMP: begin
        // Strict compare keeps the earliest particle on a tie.
        if ((k_r == '0) || (pot_rd_r < best_pot_r)) begin
          best_pot_nxt = pot_rd_r;
          best_idx_nxt = pos_rd_r.idx;
        end
        if (k_r + 1'b1 == n_r) begin
          found_nxt = 1'b1;
          st_nxt    = S_FIN;
        end else begin
          k_nxt  = k_r + 1'b1;
          st_nxt = S_MRD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.center_found = found_r;
          out_nxt.center_index = found_r ? best_idx_r : '0;
          out_nxt.min_potential = found_r ? best_pot_r : '0;
          st_nxt               = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      found_r     <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    posi_r     <= posi_nxt;
    acc_r      <= acc_nxt;
    potj_r     <= potj_nxt;
    best_pot_r <= best_pot_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.center_found |->
      out_data.center_index == '0 && out_data.min_potential == '0)
    else $error("result without a center carries nonzero fields");

  a_found_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.center_found |->
      out_data.min_potential[POT_W-1] || out_data.min_potential == '0)
    else $error("least potential is positive");

  a_root_owner: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> st_r == S_ROOT)
    else $error("root unit finished outside its wait state");

  a_sq_owner: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> st_r == S_SQ)
    else $error("distance unit finished outside its wait state");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_RDJ |-> j_r > i_r && j_r < n_r)
    else $error("pair indexes out of order");
`endif

endmodule

@@ rtl/pmpc_sq_sum.sv @@
module pmpc_sq_sum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  pmpc_pkg::pos3_t             pos_a,
  input  pmpc_pkg::pos3_t             pos_b,
  input  logic [pmpc_pkg::BOX_W-1:0]  box,
  output logic                        done,
  output logic                        zero,
  output logic [pmpc_pkg::SQ_W-1:0]   sum
);

  logic [pmpc_pkg::POS_W-1:0]   ax_x_r, ax_y_r, ax_z_r;
  logic [pmpc_pkg::POS_W-1:0]   sel;
  logic [2*pmpc_pkg::POS_W-1:0] prod_r;
  logic [pmpc_pkg::SQ_W-1:0]    sum_r;
  logic [1:0]                   cnt_r;
  logic                         busy_r;
  logic                         done_r;

  // Minimum-image distance along one axis of the periodic box.
  function automatic logic [pmpc_pkg::POS_W-1:0] axis_dist(
    input logic [pmpc_pkg::POS_W-1:0] a,
    input logic [pmpc_pkg::POS_W-1:0] b,
    input logic [pmpc_pkg::BOX_W-1:0] bx
  );
    logic [pmpc_pkg::POS_W-1:0] d;
    logic [pmpc_pkg::POS_W-1:0] e;
    d = (a > b) ? a - b : b - a;
    e = bx - d;
    if (d <= bx) begin
      axis_dist = (d < e) ? d : e;
    end else begin
      axis_dist = d - bx;
    end
  endfunction

  // Pick the axis that the shared multiplier squares this cycle.
  always_comb begin
    unique case (cnt_r)
      2'd0:    sel = ax_x_r;
      2'd1:    sel = ax_y_r;
      default: sel = ax_z_r;
    endcase
  end

  // Axis distances on start, then one square and one add per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= busy_r && (cnt_r == 2'd3);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ax_x_r <= axis_dist(pos_a.x, pos_b.x, box);
      ax_y_r <= axis_dist(pos_a.y, pos_b.y, box);
      ax_z_r <= axis_dist(pos_a.z, pos_b.z, box);
      sum_r  <= '0;
    end else if (busy_r) begin
      prod_r <= sel * sel;
      if (cnt_r != 2'd0) begin
        sum_r <= sum_r + pmpc_pkg::SQ_W'(prod_r);
      end
    end
  end

  assign done = done_r;
  assign sum  = sum_r;
  assign zero = (sum_r == '0);

endmodule

@@ rtl/pmpc_root_div.sv @@
module pmpc_root_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pmpc_pkg::SQ_W-1:0]   radicand,
  output logic                        done,
  output logic [pmpc_pkg::INV_W-1:0]  inv
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ROOT = 3'b010,
    PH_DIV  = 3'b100
  } ph_t;

  ph_t                            ph_r, ph_nxt;
  logic [pmpc_pkg::RAD_W-1:0]     rad_r, rad_nxt;
  logic [pmpc_pkg::ROOT_W-1:0]    root_r, root_nxt;
  logic [pmpc_pkg::REM_W-1:0]     rem_r, rem_nxt;
  logic [pmpc_pkg::INV_W-1:0]     q_r, q_nxt;
  logic [pmpc_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic                           done_r, done_nxt;
  logic [pmpc_pkg::REM_W-1:0]     cand, trial;
  logic [pmpc_pkg::REM_W:0]       diff;
  logic                           ge;

  // One shared subtract-and-compare serves both the square root and the divide.
  always_comb begin
    if (ph_r == PH_ROOT) begin
      cand  = {rem_r[pmpc_pkg::REM_W-3:0], rad_r[pmpc_pkg::RAD_W-1 -: 2]};
      trial = pmpc_pkg::REM_W'({root_r, 2'b01});
    end else begin
      cand  = {rem_r[pmpc_pkg::REM_W-2:0], (step_r == '0)};
      trial = pmpc_pkg::REM_W'(root_r);
    end
    diff = {1'b0, cand} - {1'b0, trial};
    ge   = ~diff[pmpc_pkg::REM_W];
  end

  // Root: two radicand bits per cycle. Divide: one quotient bit per cycle.
  always_comb begin
    ph_nxt   = ph_r;
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    unique case (ph_r)
      PH_IDLE: begin
        if (start) begin
          ph_nxt   = PH_ROOT;
          rad_nxt  = pmpc_pkg::RAD_W'(radicand);
          root_nxt = '0;
          rem_nxt  = '0;
          step_nxt = '0;
        end
      end
      PH_ROOT: begin
        rad_nxt  = {rad_r[pmpc_pkg::RAD_W-3:0], 2'b00};
        rem_nxt  = ge ? diff[pmpc_pkg::REM_W-1:0] : cand;
        root_nxt = {root_r[pmpc_pkg::ROOT_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == pmpc_pkg::STEP_W'(pmpc_pkg::ROOT_W - 1)) begin
          ph_nxt   = PH_DIV;
          rem_nxt  = '0;
          step_nxt = '0;
        end
      end
      PH_DIV: begin
        rem_nxt  = ge ? diff[pmpc_pkg::REM_W-1:0] : cand;
        q_nxt    = {q_r[pmpc_pkg::INV_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == pmpc_pkg::STEP_W'(pmpc_pkg::NUM_W - 1)) begin
          ph_nxt   = PH_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: begin
        ph_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
  end

  assign done = done_r;
  assign inv  = q_r;

endmodule
